[hw/rtl/mmcspi_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmcspi_pkg
// Shared types and codes of the MMC SPI host sequencer.
// ----------------------------------------------------------------------------
package mmcspi_pkg;

   localparam int RUN_DEPTH = 20;
   localparam int RUN_IDX_W = 5;

   typedef enum logic [3:0] {
      OP_INIT       = 4'd0,
      OP_BEGIN_READ = 4'd1,
      OP_READ_BYTE  = 4'd2,
      OP_END_READ   = 4'd3,
      OP_BEGIN_WR   = 4'd4,
      OP_WRITE_BYTE = 4'd5,
      OP_END_WR     = 4'd6,
      OP_POWER_OFF  = 4'd7,
      OP_CARD_BYTE  = 4'd8,
      OP_MS_TICK    = 4'd9
   } opcode_type;

   typedef enum logic [2:0] {
      ACT_SEND      = 3'd0,
      ACT_RECEIVE   = 3'd1,
      ACT_SELECT    = 3'd2,
      ACT_DESELECT  = 3'd3,
      ACT_POWER_ON  = 3'd4,
      ACT_POWER_OFF = 3'd5,
      ACT_REPLY     = 3'd6,
      ACT_WAIT_TICK = 3'd7
   } action_type;

   typedef enum logic [3:0] {
      PH_IDLE, PH_CMD0_R1, PH_OPC_PAUSE, PH_CMD1_R1, PH_BLK_PAUSE, PH_BLK_R1,
      PH_RD_R1, PH_RD_TOKEN, PH_RD_TICK, PH_RD_BYTE, PH_WR_R1, PH_EW_SKIP,
      PH_EW_BUSY
   } phase_type;

   typedef enum logic [2:0] {
      REG_BLOCK_LENGTH = 3'd0,
      REG_RESP_POLL    = 3'd1,
      REG_TOKEN_POLL   = 3'd2,
      REG_IDLE_RETRY   = 3'd3,
      REG_OPCOND_RETRY = 3'd4
   } reg_index_type;

   typedef struct packed {
      action_type act;
      logic [7:0] value;
      logic       ok;
      logic [7:0] hvalue;
   } result_type;

   localparam logic [7:0] CMD_BASE    = 8'h40;
   localparam logic [7:0] CMD_CRC     = 8'h95;
   localparam logic [7:0] START_TOKEN = 8'hfe;
   localparam logic [7:0] FILL_BYTE   = 8'hff;
   localparam logic [7:0] R1_IDLE     = 8'h01;

   function automatic result_type mk(action_type a, logic [7:0] v, logic ok,
                                     logic [7:0] hv);
      result_type r;
      r.act = a;
      r.value = v;
      r.ok = ok;
      r.hvalue = hv;
      return r;
   endfunction

endpackage

[hw/rtl/mmc_spi_host_sequencer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmc_spi_host_sequencer
// Host side sequencer of an MMC card in SPI mode.
// ----------------------------------------------------------------------------
// Usage: the req_ channel carries host requests, card bytes and ms ticks; the
// rsp_ channel returns bus actions and host replies, rsp_run_end marking the
// last result caused by one request. The csr_ port writes the limit and
// block length registers; csr_ready is always high.
// Latency: the first result of an item appears the cycle after its transfer.
// Flow: an item producing N results (N up to 19) holds the result channel for
// its run; the next item is taken in the cycle the last result of the previous
// run transfers, and items without results never hold the request channel.
// The run is held in one result register bank and read out by an index.
// Reset clears the phase, counters and run length, and loads the register defaults.
// When the receiver stalls, the current result holds and new items stall.
// ----------------------------------------------------------------------------
module mmc_spi_host_sequencer
   import mmcspi_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [3:0]  req_opcode,
   input  logic [31:0] req_sector,
   input  logic [7:0]  req_write_value,
   input  logic [7:0]  req_card_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_bus_action,
   output logic [7:0]  rsp_bus_value,
   output logic        rsp_host_ok,
   output logic [7:0]  rsp_host_value,
   output logic        rsp_run_end,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [12:0] csr_wdata
);

   logic [12:0] blk_len_ff;
   logic [7:0]  resp_lim_ff, tok_lim_ff, idle_lim_ff;
   logic [10:0] opc_lim_ff;

   phase_type   phase_ff, phase_in;
   logic [10:0] retry_ff, retry_in;
   logic [7:0]  poll_ff, poll_in;
   logic [7:0]  last_ff, last_in;

   result_type            run_ff [RUN_DEPTH];
   result_type            run_in [RUN_DEPTH];
   logic [RUN_IDX_W-1:0]  len_ff, len_in;
   logic [RUN_IDX_W-1:0]  idx_ff;

   logic        accept, last_xfer;
   logic [7:0]  r1_pc;
   logic        r1_more;
   logic [10:0] retry_inc;
   logic [7:0]  cv;

   assign csr_ready = 1'b1;
   assign cv        = req_card_value;

   assign rsp_valid      = idx_ff < len_ff;
   assign rsp_bus_action = run_ff[idx_ff].act;
   assign rsp_bus_value  = run_ff[idx_ff].value;
   assign rsp_host_ok    = run_ff[idx_ff].ok;
   assign rsp_host_value = run_ff[idx_ff].hvalue;
   assign rsp_run_end    = idx_ff == len_ff - 5'd1;

   assign last_xfer = rsp_valid && !rsp_stall && rsp_run_end;
   assign req_stall = rsp_valid && !last_xfer;
   assign accept    = req_valid && !req_stall;

   assign r1_pc     = poll_ff + 8'd1;
   assign r1_more   = cv[7] && (r1_pc < resp_lim_ff);
   assign retry_inc = retry_ff + 11'd1;

   always_comb begin
      logic [RUN_IDX_W-1:0] n;
      logic [31:0]          arg;
      logic [7:0]           cidx;
      logic                 do_cmd;
      n = '0;
      arg = '0;
      cidx = '0;
      do_cmd = 1'b0;
      phase_in = phase_ff;
      retry_in = retry_ff;
      poll_in  = poll_ff;
      last_in  = last_ff;
      for (int i = 0; i < RUN_DEPTH; i++) run_in[i] = '0;

      if (req_opcode == OP_CARD_BYTE) begin
         last_in = cv;
         case (phase_ff)
            PH_CMD0_R1, PH_CMD1_R1, PH_BLK_R1, PH_RD_R1, PH_WR_R1: begin
               if (r1_more) begin
                  poll_in = r1_pc;
                  run_in[n] = mk(ACT_RECEIVE, '0, 1'b0, '0); n = n + 5'd1;
               end else begin
                  poll_in = '0;
                  case (phase_ff)
                     PH_CMD0_R1: begin
                        if (cv == R1_IDLE) begin
                           run_in[n] = mk(ACT_SEND, FILL_BYTE, 1'b0, '0); n = n + 5'd1;
                           run_in[n] = mk(ACT_SEND, FILL_BYTE, 1'b0, '0); n = n + 5'd1;
                           run_in[n] = mk(ACT_DESELECT, '0, 1'b0, '0); n = n + 5'd1;
                           run_in[n] = mk(ACT_SEND, FILL_BYTE, 1'b0, '0); n = n + 5'd1;
                           for (int i = 0; i < 10; i++) begin
                              run_in[n] = mk(ACT_SEND, FILL_BYTE, 1'b0, '0);
                              n = n + 5'd1;
                           end
                           run_in[n] = mk(ACT_WAIT_TICK, '0, 1'b0, '0); n = n + 5'd1;
                           phase_in = PH_OPC_PAUSE;
                        end else begin
                           retry_in = retry_inc;
                           if (retry_inc < {3'd0, idle_lim_ff}) begin
                              do_cmd = 1'b1;
                              cidx = 8'd0;
                           end else begin
                              run_in[n] = mk(ACT_SEND, FILL_BYTE, 1'b0, '0); n = n + 5'd1;
                              run_in[n] = mk(ACT_SEND, FILL_BYTE, 1'b0, '0); n = n + 5'd1;
                              run_in[n] = mk(ACT_DESELECT, '0, 1'b0, '0); n = n + 5'd1;
                              run_in[n] = mk(ACT_SEND, FILL_BYTE, 1'b0, '0); n = n + 5'd1;
                              run_in[n] = mk(ACT_REPLY, '0, 1'b0, '0); n = n + 5'd1;
                              phase_in = PH_IDLE;
                           end
                        end
                     end
                     PH_CMD1_R1: begin
                        run_in[n] = mk(ACT_DESELECT, '0, 1'b0, '0); n = n + 5'd1;
                        for (int i = 0; i < 10; i++) begin
                           run_in[n] = mk(ACT_SEND, FILL_BYTE, 1'b0, '0);
                           n = n + 5'd1;
                        end
                        if (cv == 8'd0) begin
                           run_in[n] = mk(ACT_SEND, FILL_BYTE, 1'b0, '0); n = n + 5'd1;
                           run_in[n] = mk(ACT_SEND, FILL_BYTE, 1'b0, '0); n = n + 5'd1;
                           run_in[n] = mk(ACT_DESELECT, '0, 1'b0, '0); n = n + 5'd1;
                           run_in[n] = mk(ACT_SEND, FILL_BYTE, 1'b0, '0); n = n + 5'd1;
                           run_in[n] = mk(ACT_WAIT_TICK, '0, 1'b0, '0); n = n + 5'd1;
                           phase_in = PH_BLK_PAUSE;
                        end else begin
                           retry_in = retry_inc;
                           if (retry_inc < opc_lim_ff) begin
                              run_in[n] = mk(ACT_SELECT, '0, 1'b0, '0); n = n + 5'd1;
                              do_cmd = 1'b1;
                              cidx = 8'd1;
                           end else begin
                              run_in[n] = mk(ACT_SEND, FILL_BYTE, 1'b0, '0); n = n + 5'd1;
                              run_in[n] = mk(ACT_SEND, FILL_BYTE, 1'b0, '0); n = n + 5'd1;
                              run_in[n] = mk(ACT_DESELECT, '0, 1'b0, '0); n = n + 5'd1;
                              run_in[n] = mk(ACT_SEND, FILL_BYTE, 1'b0, '0); n = n + 5'd1;
                              run_in[n] = mk(ACT_POWER_OFF, '0, 1'b0, '0); n = n + 5'd1;
                              run_in[n] = mk(ACT_REPLY, '0, 1'b0, '0); n = n + 5'd1;
                              phase_in = PH_IDLE;
                           end
                        end
                     end
                     PH_BLK_R1: begin
                        run_in[n] = mk(ACT_SEND, FILL_BYTE, 1'b0, '0); n = n + 5'd1;
                        run_in[n] = mk(ACT_SEND, FILL_BYTE, 1'b0, '0); n = n + 5'd1;
                        run_in[n] = mk(ACT_DESELECT, '0, 1'b0, '0); n = n + 5'd1;
                        run_in[n] = mk(ACT_SEND, FILL_BYTE, 1'b0, '0); n = n + 5'd1;
                        run_in[n] = mk(ACT_REPLY, '0, 1'b1, '0); n = n + 5'd1;
                        phase_in = PH_IDLE;
                     end
                     PH_RD_R1: begin
                        if (cv != 8'd0) begin
                           run_in[n] = mk(ACT_SEND, FILL_BYTE, 1'b0, '0); n = n + 5'd1;
                           run_in[n] = mk(ACT_SEND, FILL_BYTE, 1'b0, '0); n = n + 5'd1;
                           run_in[n] = mk(ACT_DESELECT, '0, 1'b0, '0); n = n + 5'd1;
                           run_in[n] = mk(ACT_SEND, FILL_BYTE, 1'b0, '0); n = n + 5'd1;
                           run_in[n] = mk(ACT_REPLY, '0, 1'b0, '0); n = n + 5'd1;
                           phase_in = PH_IDLE;
                        end else begin
                           run_in[n] = mk(ACT_RECEIVE, '0, 1'b0, '0); n = n + 5'd1;
                           phase_in = PH_RD_TOKEN;
                        end
                     end
                     default: begin
                        // write command response
                        if (cv != 8'd0) begin
                           run_in[n] = mk(ACT_SEND, FILL_BYTE, 1'b0, '0); n = n + 5'd1;
                           run_in[n] = mk(ACT_SEND, FILL_BYTE, 1'b0, '0); n = n + 5'd1;
                           run_in[n] = mk(ACT_DESELECT, '0, 1'b0, '0); n = n + 5'd1;
                           run_in[n] = mk(ACT_SEND, FILL_BYTE, 1'b0, '0); n = n + 5'd1;
                           run_in[n] = mk(ACT_REPLY, '0, 1'b0, '0); n = n + 5'd1;
                        end else begin
                           run_in[n] = mk(ACT_SEND, FILL_BYTE, 1'b0, '0); n = n + 5'd1;
                           run_in[n] = mk(ACT_SEND, FILL_BYTE, 1'b0, '0); n = n + 5'd1;
                           run_in[n] = mk(ACT_SEND, START_TOKEN, 1'b0, '0); n = n + 5'd1;
                           run_in[n] = mk(ACT_REPLY, '0, 1'b1, '0); n = n + 5'd1;
                        end
                        phase_in = PH_IDLE;
                     end
                  endcase
               end
            end
            PH_RD_TOKEN: begin
               if (cv == START_TOKEN) begin
                  poll_in = '0;
                  run_in[n] = mk(ACT_REPLY, '0, 1'b1, '0); n = n + 5'd1;
                  phase_in = PH_IDLE;
               end else begin
                  poll_in = r1_pc;
                  run_in[n] = mk(ACT_WAIT_TICK, '0, 1'b0, '0); n = n + 5'd1;
                  phase_in = PH_RD_TICK;
               end
            end
            PH_RD_BYTE: begin
               run_in[n] = mk(ACT_REPLY, '0, 1'b1, cv); n = n + 5'd1;
               phase_in = PH_IDLE;
            end
            PH_EW_SKIP: begin
               run_in[n] = mk(ACT_RECEIVE, '0, 1'b0, '0); n = n + 5'd1;
               phase_in = PH_EW_BUSY;
            end
            PH_EW_BUSY: begin
               if (cv == 8'd0) begin
                  run_in[n] = mk(ACT_RECEIVE, '0, 1'b0, '0); n = n + 5'd1;
               end else begin
                  run_in[n] = mk(ACT_SEND, FILL_BYTE, 1'b0, '0); n = n + 5'd1;
                  run_in[n] = mk(ACT_SEND, FILL_BYTE, 1'b0, '0); n = n + 5'd1;
                  run_in[n] = mk(ACT_DESELECT, '0, 1'b0, '0); n = n + 5'd1;
                  run_in[n] = mk(ACT_SEND, FILL_BYTE, 1'b0, '0); n = n + 5'd1;
                  run_in[n] = mk(ACT_REPLY, '0, 1'b1, '0); n = n + 5'd1;
                  phase_in = PH_IDLE;
               end
            end
            default: ;
         endcase
      end else if (req_opcode == OP_MS_TICK) begin
         case (phase_ff)
            PH_OPC_PAUSE: begin
               retry_in = '0;
               run_in[n] = mk(ACT_SELECT, '0, 1'b0, '0); n = n + 5'd1;
               do_cmd = 1'b1;
               cidx = 8'd1;
               phase_in = PH_CMD1_R1;
            end
            PH_BLK_PAUSE: begin
               run_in[n] = mk(ACT_SELECT, '0, 1'b0, '0); n = n + 5'd1;
               do_cmd = 1'b1;
               cidx = 8'd16;
               arg = {19'd0, blk_len_ff};
               phase_in = PH_BLK_R1;
            end
            PH_RD_TICK: begin
               if (poll_ff < tok_lim_ff) begin
                  run_in[n] = mk(ACT_RECEIVE, '0, 1'b0, '0); n = n + 5'd1;
                  phase_in = PH_RD_TOKEN;
               end else begin
                  poll_in = '0;
                  run_in[n] = mk(ACT_REPLY, '0, 1'b0, '0); n = n + 5'd1;
                  phase_in = PH_IDLE;
               end
            end
            default: ;
         endcase
      end else if (phase_ff == PH_IDLE) begin
         case (req_opcode)
            OP_INIT: begin
               run_in[n] = mk(ACT_POWER_ON, '0, 1'b0, '0); n = n + 5'd1;
               for (int i = 0; i < 10; i++) begin
                  run_in[n] = mk(ACT_SEND, FILL_BYTE, 1'b0, '0);
                  n = n + 5'd1;
               end
               run_in[n] = mk(ACT_SELECT, '0, 1'b0, '0); n = n + 5'd1;
               retry_in = '0;
               do_cmd = 1'b1;
               cidx = 8'd0;
               phase_in = PH_CMD0_R1;
            end
            OP_BEGIN_READ, OP_BEGIN_WR: begin
               run_in[n] = mk(ACT_SELECT, '0, 1'b0, '0); n = n + 5'd1;
               do_cmd = 1'b1;
               cidx = (req_opcode == OP_BEGIN_READ) ? 8'd17 : 8'd24;
               arg = req_sector;
               phase_in = (req_opcode == OP_BEGIN_READ) ? PH_RD_R1 : PH_WR_R1;
            end
            OP_READ_BYTE: begin
               run_in[n] = mk(ACT_RECEIVE, '0, 1'b0, '0); n = n + 5'd1;
               phase_in = PH_RD_BYTE;
            end
            OP_END_READ: begin
               run_in[n] = mk(ACT_SEND, FILL_BYTE, 1'b0, '0); n = n + 5'd1;
               run_in[n] = mk(ACT_SEND, FILL_BYTE, 1'b0, '0); n = n + 5'd1;
               run_in[n] = mk(ACT_DESELECT, '0, 1'b0, '0); n = n + 5'd1;
               run_in[n] = mk(ACT_SEND, FILL_BYTE, 1'b0, '0); n = n + 5'd1;
               run_in[n] = mk(ACT_REPLY, '0, 1'b1, '0); n = n + 5'd1;
            end
            OP_WRITE_BYTE: begin
               run_in[n] = mk(ACT_SEND, req_write_value, 1'b0, '0); n = n + 5'd1;
               run_in[n] = mk(ACT_REPLY, '0, 1'b1, '0); n = n + 5'd1;
            end
            OP_END_WR: begin
               run_in[n] = mk(ACT_SEND, FILL_BYTE, 1'b0, '0); n = n + 5'd1;
               run_in[n] = mk(ACT_SEND, FILL_BYTE, 1'b0, '0); n = n + 5'd1;
               run_in[n] = mk(ACT_RECEIVE, '0, 1'b0, '0); n = n + 5'd1;
               phase_in = PH_EW_SKIP;
            end
            OP_POWER_OFF: begin
               run_in[n] = mk(ACT_POWER_OFF, '0, 1'b0, '0); n = n + 5'd1;
               run_in[n] = mk(ACT_REPLY, '0, 1'b1, '0); n = n + 5'd1;
            end
            default: ;
         endcase
      end

      // append a command frame and its first response receive
      if (do_cmd) begin
         run_in[n] = mk(ACT_SEND, CMD_BASE | cidx, 1'b0, '0); n = n + 5'd1;
         run_in[n] = mk(ACT_SEND, arg[31:24], 1'b0, '0); n = n + 5'd1;
         run_in[n] = mk(ACT_SEND, arg[23:16], 1'b0, '0); n = n + 5'd1;
         run_in[n] = mk(ACT_SEND, arg[15:8], 1'b0, '0); n = n + 5'd1;
         run_in[n] = mk(ACT_SEND, arg[7:0], 1'b0, '0); n = n + 5'd1;
         run_in[n] = mk(ACT_SEND, CMD_CRC, 1'b0, '0); n = n + 5'd1;
         run_in[n] = mk(ACT_RECEIVE, '0, 1'b0, '0); n = n + 5'd1;
         poll_in = '0;
      end
      len_in = n;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         blk_len_ff  <= 13'd512;
         resp_lim_ff <= 8'd255;
         tok_lim_ff  <= 8'd255;
         idle_lim_ff <= 8'd255;
         opc_lim_ff  <= 11'd2047;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_BLOCK_LENGTH: blk_len_ff  <= csr_wdata;
            REG_RESP_POLL:    resp_lim_ff <= csr_wdata[7:0];
            REG_TOKEN_POLL:   tok_lim_ff  <= csr_wdata[7:0];
            REG_IDLE_RETRY:   idle_lim_ff <= csr_wdata[7:0];
            REG_OPCOND_RETRY: opc_lim_ff  <= csr_wdata[10:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         retry_ff <= '0;
         poll_ff  <= '0;
         last_ff  <= '0;
         len_ff   <= '0;
         idx_ff   <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         retry_ff <= retry_in;
         poll_ff  <= poll_in;
         last_ff  <= last_in;
         len_ff   <= len_in;
         idx_ff   <= '0;
      end else if (rsp_valid && !rsp_stall) begin
         // advance to the next result of the run
         idx_ff <= idx_ff + 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         run_ff <= run_in;
      end
   end

endmodule
